@@ hdl/fba_pkg.sv @@
// Shared types, codes and a helper function of the frame bitmap allocator.
package fba_pkg;

   localparam int ADDR_W        = 32;
   localparam int WORDS_W       = 11;
   localparam int BITS_PER_WORD = 32;
   localparam int BIT_IDX_W     = 5;
   localparam int FRAME_SHIFT   = 12;
   localparam int WORD_SHIFT    = 17;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_R0_BASE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_R0_WORDS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_R0_USABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_R1_BASE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_R1_WORDS  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_R1_USABLE = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_REL_CHECK,
      ST_REL_MOD
   } state_type;

   // Returns the index of the lowest clear bit of a bitmap word.
   function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [BITS_PER_WORD-1:0] word);
      logic [BIT_IDX_W-1:0] result;
      result = '0;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
         if (!word[i]) begin
            result = BIT_IDX_W'(i);
         end
      end
      return result;
   endfunction

endpackage

@@ hdl/fba_bitmap_ram.sv @@
// Bitmap RAM with one write port and one registered read port.
module fba_bitmap_ram #(
   parameter int DEPTH = 2048,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [AW-1:0]                        wr_addr,
   input  logic [fba_pkg::BITS_PER_WORD-1:0]    wr_data,
   input  logic [AW-1:0]                        rd_addr,
   output logic [fba_pkg::BITS_PER_WORD-1:0]    rd_data
);
   import fba_pkg::*;

   logic [BITS_PER_WORD-1:0] mem [DEPTH];
   logic [BITS_PER_WORD-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/frame_bitmap_allocator_top.sv @@
// Top level of the first-fit 4 KiB frame allocator over two configured regions.
//
// After reset the block clears its bitmap RAM one word per cycle with busy high;
// configuration writes are taken during that time. A transaction is taken when
// start is high and busy is low. An allocation reads one bitmap word per cycle,
// except when it moves on to the next region, through the single read port of
// the RAM; a release checks each region in turn and, for each region that holds
// the address, reads its bitmap word and then writes it back with the bit
// cleared. The result shows on the rsp_ ports for one cycle with rsp_valid and
// busy low at the same time; the receiver cannot stall it.
module frame_bitmap_allocator_top #(
   parameter int NUM_REGIONS = 2,
   parameter int MAX_WORDS   = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [fba_pkg::ADDR_W-1:0]         req_release_addr,
   output logic                               rsp_valid,
   output logic [fba_pkg::ADDR_W-1:0]         rsp_frame_addr,
   output logic                               rsp_status,
   input  logic                               csr_we,
   input  logic [fba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fba_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fba_pkg::*;

   localparam int DEPTH  = NUM_REGIONS * MAX_WORDS;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WIDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int EW     = $clog2(MAX_WORDS + 1);
   localparam int HW     = (EW + 18 > 33) ? EW + 18 : 33;
   localparam logic LAST_R = 1'(NUM_REGIONS - 1);
   localparam logic [16:0] MAXW_EXT = 17'(MAX_WORDS);

   state_type state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               cur_r_ff, cur_r_in;
   logic [EW-1:0]      scan_i_ff, scan_i_in;
   logic               pend_ff, pend_in;
   logic               pend_r_ff, pend_r_in;
   logic [WIDX_W-1:0]  pend_i_ff, pend_i_in;
   logic [ADDR_W-1:0]  rel_addr_ff, rel_addr_in;
   logic               hit_any_ff, hit_any_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_frame_addr_ff, rsp_frame_addr_in;
   logic               rsp_status_ff, rsp_status_in;

   logic [ADDR_W-1:0]  base_ff [2];
   logic [ADDR_W-1:0]  base_in [2];
   logic [WORDS_W-1:0] words_ff [2];
   logic [WORDS_W-1:0] words_in [2];
   logic               usable_ff [2];
   logic               usable_in [2];

   logic [EW-1:0]      eff_words [2];
   logic [16:0]        words_ext [2];

   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [BITS_PER_WORD-1:0] mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic [BITS_PER_WORD-1:0] rd_word;

   logic [ADDR_W-1:0]    sel_base;
   logic [EW-1:0]        sel_eff;
   logic                 sel_usable;
   logic                 r_last;
   logic                 can_issue;
   logic                 exhausted;
   logic                 found;
   logic [BIT_IDX_W-1:0] zero_bit;
   logic [ADDR_W-1:0]    alloc_addr;
   logic [ADDR_W-1:0]    rel_off;
   logic [ADDR_W-1:0]    rel_off_word;
   logic [WIDX_W-1:0]    rel_widx;
   logic [BIT_IDX_W-1:0] rel_bit;
   logic [HW-1:0]        rel_hi;
   logic                 rel_hit;

   function automatic logic [AW-1:0] word_addr(input logic r, input logic [WIDX_W-1:0] i);
      return AW'(i) + (r ? AW'(MAX_WORDS) : AW'(0));
   endfunction

   fba_bitmap_ram #(
      .DEPTH(DEPTH)
   ) u_bitmap_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(rd_word)
   );

   always_comb begin
      base_in   = base_ff;
      words_in  = words_ff;
      usable_in = usable_ff;
      if (csr_we) begin
         case (csr_index)
            REG_R0_BASE:   base_in[0]   = csr_wdata[ADDR_W-1:0];
            REG_R0_WORDS:  words_in[0]  = csr_wdata[WORDS_W-1:0];
            REG_R0_USABLE: usable_in[0] = csr_wdata[0];
            REG_R1_BASE:   base_in[1]   = csr_wdata[ADDR_W-1:0];
            REG_R1_WORDS:  words_in[1]  = csr_wdata[WORDS_W-1:0];
            REG_R1_USABLE: usable_in[1] = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int r = 0; r < 2; r++) begin
         words_ext[r] = 17'(words_ff[r]);
         eff_words[r] = (words_ext[r] > MAXW_EXT) ? MAXW_EXT[EW-1:0] : words_ext[r][EW-1:0];
      end
   end

   always_comb begin
      sel_base     = base_ff[cur_r_ff];
      sel_eff      = eff_words[cur_r_ff];
      sel_usable   = usable_ff[cur_r_ff];
      r_last       = (cur_r_ff == LAST_R);
      can_issue    = sel_usable && (scan_i_ff < sel_eff);
      exhausted    = r_last && !can_issue;
      found        = pend_ff && (rd_word != '1);
      zero_bit     = first_zero(rd_word);
      alloc_addr   = base_ff[pend_r_ff] + (ADDR_W'(pend_i_ff) << WORD_SHIFT)
                     + (ADDR_W'(zero_bit) << FRAME_SHIFT);
      rel_off      = rel_addr_ff - sel_base;
      rel_off_word = rel_off >> WORD_SHIFT;
      rel_widx     = rel_off_word[WIDX_W-1:0];
      rel_bit      = rel_off[WORD_SHIFT-1:FRAME_SHIFT];
      rel_hi       = HW'(sel_base) + (HW'(sel_eff) << WORD_SHIFT);
      rel_hit      = (rel_addr_ff >= sel_base) && (HW'(rel_addr_ff) < rel_hi);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_cmd == CMD_ALLOC) ? ST_SCAN : ST_REL_CHECK;
            end
         end
         ST_SCAN: begin
            if (found || exhausted) begin
               state_in = ST_IDLE;
            end
         end
         ST_REL_CHECK: begin
            if (rel_hit) begin
               state_in = ST_REL_MOD;
            end else if (r_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_REL_MOD: begin
            state_in = r_last ? ST_IDLE : ST_REL_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in            = clr_ff;
      cur_r_in          = cur_r_ff;
      scan_i_in         = scan_i_ff;
      pend_in           = pend_ff;
      pend_r_in         = pend_r_ff;
      pend_i_in         = pend_i_ff;
      rel_addr_in       = rel_addr_ff;
      hit_any_in        = hit_any_ff;
      rsp_valid_in      = 1'b0;
      rsp_frame_addr_in = rsp_frame_addr_ff;
      rsp_status_in     = rsp_status_ff;
      mem_we            = 1'b0;
      mem_waddr         = clr_ff;
      mem_wdata         = '0;
      mem_raddr         = word_addr(cur_r_ff, scan_i_ff[WIDX_W-1:0]);
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (start) begin
               cur_r_in    = 1'b0;
               scan_i_in   = '0;
               pend_in     = 1'b0;
               hit_any_in  = 1'b0;
               rel_addr_in = req_release_addr;
            end
         end
         ST_SCAN: begin
            pend_in = 1'b0;
            if (found) begin
               mem_we            = 1'b1;
               mem_waddr         = word_addr(pend_r_ff, pend_i_ff);
               mem_wdata         = rd_word | (BITS_PER_WORD'(1) << zero_bit);
               rsp_valid_in      = 1'b1;
               rsp_frame_addr_in = alloc_addr;
               rsp_status_in     = STATUS_OK;
            end else if (exhausted) begin
               rsp_valid_in      = 1'b1;
               rsp_frame_addr_in = '0;
               rsp_status_in     = STATUS_FAIL;
            end else if (can_issue) begin
               pend_in   = 1'b1;
               pend_r_in = cur_r_ff;
               pend_i_in = scan_i_ff[WIDX_W-1:0];
               scan_i_in = scan_i_ff + 1'b1;
            end else begin
               cur_r_in  = cur_r_ff + 1'b1;
               scan_i_in = '0;
            end
         end
         ST_REL_CHECK: begin
            mem_raddr = word_addr(cur_r_ff, rel_widx);
            if (!rel_hit) begin
               if (r_last) begin
                  rsp_valid_in      = 1'b1;
                  rsp_frame_addr_in = '0;
                  rsp_status_in     = hit_any_ff ? STATUS_OK : STATUS_FAIL;
               end else begin
                  cur_r_in = cur_r_ff + 1'b1;
               end
            end
         end
         ST_REL_MOD: begin
            mem_we     = 1'b1;
            mem_waddr  = word_addr(cur_r_ff, rel_widx);
            mem_wdata  = rd_word & ~(BITS_PER_WORD'(1) << rel_bit);
            hit_any_in = 1'b1;
            if (r_last) begin
               rsp_valid_in      = 1'b1;
               rsp_frame_addr_in = '0;
               rsp_status_in     = STATUS_OK;
            end else begin
               cur_r_in = cur_r_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cur_r_ff     <= 1'b0;
         scan_i_ff    <= '0;
         pend_ff      <= 1'b0;
         hit_any_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 2; r++) begin
            base_ff[r]   <= '0;
            words_ff[r]  <= '0;
            usable_ff[r] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_r_ff     <= cur_r_in;
         scan_i_ff    <= scan_i_in;
         pend_ff      <= pend_in;
         hit_any_ff   <= hit_any_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         words_ff     <= words_in;
         usable_ff    <= usable_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_r_ff         <= pend_r_in;
      pend_i_ff         <= pend_i_in;
      rel_addr_ff       <= rel_addr_in;
      rsp_frame_addr_ff <= rsp_frame_addr_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_addr = rsp_frame_addr_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

@@ hdl/fba_checker.sv @@
// Port-level checker of the frame bitmap allocator and its bind to the top level.
module fba_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [fba_pkg::ADDR_W-1:0] rsp_frame_addr,
   input logic                       rsp_status
);
   import fba_pkg::*;

   // A result is shown only as the block returns to idle.
   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // A result strobe, one per transaction, is of a single cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // An accepted transaction keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted transaction");

   // A failed transaction returns a zero frame address.
   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FAIL) |-> (rsp_frame_addr == '0))
      else $error("failed transaction with nonzero frame address");

endmodule

bind frame_bitmap_allocator_top fba_checker u_fba_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_frame_addr(rsp_frame_addr),
   .rsp_status    (rsp_status)
);

@@ tb/sv/frame_bitmap_allocator_checker.sv @@
`timescale 1ns / 100ps
// Checker that predicts allocator results from observed transactions and compares them.
module frame_bitmap_allocator_checker #(
   parameter int NUM_REGIONS = 2,
   parameter int MAX_WORDS   = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_cmd,
   input  logic [fba_pkg::ADDR_W-1:0]         req_release_addr,
   input  logic                               rsp_valid,
   input  logic [fba_pkg::ADDR_W-1:0]         rsp_frame_addr,
   input  logic                               rsp_status,
   input  logic                               csr_we,
   input  logic [fba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fba_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 failures,
   output int                                 pending
);
   import fba_pkg::*;

   typedef struct packed {
      logic [ADDR_W-1:0] frame_addr;
      logic              status;
   } frame_result_type;

   logic [ADDR_W-1:0]        region_base   [NUM_REGIONS];
   logic [WORDS_W-1:0]       region_words  [NUM_REGIONS];
   logic                     region_usable [NUM_REGIONS];
   logic [BITS_PER_WORD-1:0] frame_bitmap  [NUM_REGIONS * MAX_WORDS];
   frame_result_type         expected_results [$];
   int                       mismatch_count = 0;

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic int unsigned region_span_words(input int r);
      return (region_words[r] > MAX_WORDS) ? MAX_WORDS : region_words[r];
   endfunction

   function automatic frame_result_type predict_transaction(input logic cmd,
                                                            input logic [ADDR_W-1:0] addr);
      frame_result_type   res;
      int unsigned        n;
      int unsigned        idx;
      logic               found;
      logic [63:0]        lo;
      logic [63:0]        hi;
      logic [ADDR_W-1:0]  off;
      res.frame_addr = '0;
      res.status     = STATUS_FAIL;
      found          = 1'b0;
      if (cmd == CMD_ALLOC) begin
         for (int r = 0; r < NUM_REGIONS; r++) begin
            n = region_span_words(r);
            if (region_usable[r] && !found) begin
               for (int i = 0; i < n && !found; i++) begin
                  idx = r * MAX_WORDS + i;
                  for (int j = 0; j < BITS_PER_WORD && !found; j++) begin
                     if (!frame_bitmap[idx][j]) begin
                        frame_bitmap[idx][j] = 1'b1;
                        res.frame_addr = region_base[r] + (ADDR_W'(i) << WORD_SHIFT)
                                         + (ADDR_W'(j) << FRAME_SHIFT);
                        res.status = STATUS_OK;
                        found = 1'b1;
                     end
                  end
               end
            end
         end
      end else begin
         for (int r = 0; r < NUM_REGIONS; r++) begin
            n  = region_span_words(r);
            lo = {32'h0, region_base[r]};
            hi = lo + (64'(n) << WORD_SHIFT);
            if ({32'h0, addr} >= lo && {32'h0, addr} < hi) begin
               off = addr - region_base[r];
               idx = r * MAX_WORDS + (off >> WORD_SHIFT);
               frame_bitmap[idx][off[WORD_SHIFT-1:FRAME_SHIFT]] = 1'b0;
               res.status = STATUS_OK;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         for (int r = 0; r < NUM_REGIONS; r++) begin
            region_base[r]   = '0;
            region_words[r]  = '0;
            region_usable[r] = 1'b0;
         end
         for (int k = 0; k < NUM_REGIONS * MAX_WORDS; k++) begin
            frame_bitmap[k] = '0;
         end
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result with no transaction outstanding: %s %h %s %b",
                           $realtime, "frame_addr", rsp_frame_addr, "status", rsp_status);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_frame_addr !== want.frame_addr || rsp_status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: result mismatch: expected frame_addr %h status %b,",
                              $realtime, want.frame_addr, want.status);
                     $display("   got frame_addr %h status %b", rsp_frame_addr, rsp_status);
                  end
               end
            end
         end
         if (start && !busy) begin
            expected_results.push_back(predict_transaction(req_cmd, req_release_addr));
         end
         if (csr_we) begin
            case (csr_index)
               REG_R0_BASE:   region_base[0]   = csr_wdata;
               REG_R0_WORDS:  region_words[0]  = csr_wdata[WORDS_W-1:0];
               REG_R0_USABLE: region_usable[0] = csr_wdata[0];
               REG_R1_BASE:   region_base[1]   = csr_wdata;
               REG_R1_WORDS:  region_words[1]  = csr_wdata[WORDS_W-1:0];
               REG_R1_USABLE: region_usable[1] = csr_wdata[0];
               default: ;
            endcase
         end
      end
      failures <= mismatch_count;
      pending  <= expected_results.size();
   end

endmodule

@@ tb/sv/tb_frame_bitmap_allocator_top.sv @@
`timescale 1ns / 100ps
// Testbench top that drives allocate, release and region settings and gives the verdict.
module tb_frame_bitmap_allocator_top;
   import fba_pkg::*;

   localparam int NUM_REGIONS    = 2;
   localparam int MAX_WORDS      = 1024;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 235;
   localparam int SETTLE_CYCLES  = 2 * NUM_REGIONS * MAX_WORDS + 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic                   busy;
   logic                   req_cmd          = CMD_ALLOC;
   logic [ADDR_W-1:0]      req_release_addr = '0;
   logic                   rsp_valid;
   logic [ADDR_W-1:0]      rsp_frame_addr;
   logic                   rsp_status;
   logic                   csr_we           = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;
   int                     failures;
   int                     pending;
   int                     sender_idle_pct  = 37;
   int                     stall_cycles     = 0;
   logic [ADDR_W-1:0]      cfg_base  [NUM_REGIONS];
   int unsigned            cfg_words [NUM_REGIONS];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   frame_bitmap_allocator_top #(
      .NUM_REGIONS (NUM_REGIONS),
      .MAX_WORDS   (MAX_WORDS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_release_addr (req_release_addr),
      .rsp_valid        (rsp_valid),
      .rsp_frame_addr   (rsp_frame_addr),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   frame_bitmap_allocator_checker #(
      .NUM_REGIONS (NUM_REGIONS),
      .MAX_WORDS   (MAX_WORDS)
   ) frame_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_release_addr (req_release_addr),
      .rsp_valid        (rsp_valid),
      .rsp_frame_addr   (rsp_frame_addr),
      .rsp_status       (rsp_status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .pending          (pending)
   );

   always @(posedge clock) begin
      if (reset || csr_we || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_frame_bitmap_allocator_top: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic configure(input logic [ADDR_W-1:0] base0, input int unsigned words0,
                            input logic usable0, input logic [ADDR_W-1:0] base1,
                            input int unsigned words1, input logic usable1);
      write_reg(REG_R0_BASE, base0);
      write_reg(REG_R0_WORDS, CSR_DATA_W'(words0));
      write_reg(REG_R0_USABLE, CSR_DATA_W'(usable0));
      write_reg(REG_R1_BASE, base1);
      write_reg(REG_R1_WORDS, CSR_DATA_W'(words1));
      write_reg(REG_R1_USABLE, CSR_DATA_W'(usable1));
      if ($urandom_range(2) == 0) begin
         write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      end
      csr_we       <= 1'b0;
      cfg_base[0]  = base0;
      cfg_base[1]  = base1;
      cfg_words[0] = words0;
      cfg_words[1] = words1;
   endtask

   task automatic send(input logic cmd, input logic [ADDR_W-1:0] addr);
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_release_addr <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start            <= 1'b0;
         req_cmd          <= 1'($urandom_range(1));
         req_release_addr <= $urandom;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] pick_base();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'hFFFF_F000 - (ADDR_W'($urandom_range(40)) << FRAME_SHIFT);
         2: return $urandom;
         default: return $urandom & 32'hFFFF_F000;
      endcase
   endfunction

   function automatic int unsigned pick_words();
      case ($urandom_range(9))
         0: return 0;
         1: return MAX_WORDS;
         2: return $urandom_range(2047, MAX_WORDS + 1);
         3: return $urandom_range(2047);
         default: return $urandom_range(3, 1);
      endcase
   endfunction

   task automatic program_random_regions();
      logic [ADDR_W-1:0] base0;
      logic [ADDR_W-1:0] base1;
      base0 = pick_base();
      if ($urandom_range(4) == 0) begin
         base1 = base0 + (ADDR_W'($urandom_range(2)) << WORD_SHIFT);
      end else begin
         base1 = pick_base();
      end
      configure(base0, pick_words(), $urandom_range(4) != 0,
                base1, pick_words(), $urandom_range(4) != 0);
   endtask

   function automatic logic [ADDR_W-1:0] pick_release_addr();
      int unsigned r;
      int unsigned eff;
      int unsigned word;
      logic [63:0] span;
      r    = $urandom_range(NUM_REGIONS - 1);
      eff  = (cfg_words[r] > MAX_WORDS) ? MAX_WORDS : cfg_words[r];
      span = 64'(eff) << WORD_SHIFT;
      case ($urandom_range(9))
         0: return $urandom;
         1: return cfg_base[r] - 1;
         2: return ADDR_W'(64'(cfg_base[r]) + span);
         3: return ADDR_W'(64'(cfg_base[r]) + span - 1);
         default: begin
            if (eff == 0) return $urandom;
            if ($urandom_range(3) == 0) begin
               word = $urandom_range(eff - 1);
            end else begin
               word = $urandom_range((eff < 3) ? eff - 1 : 2);
            end
            return cfg_base[r] + (ADDR_W'(word) << WORD_SHIFT)
                   + (ADDR_W'($urandom_range(31)) << FRAME_SHIFT) + ADDR_W'($urandom_range(4095));
         end
      endcase
   endfunction

   initial begin
      int alloc_pct;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_HI, 32'h0000_0001);
      configure(32'h0000_0000, 1, 1'b1, 32'hFFFF_E000, 2047, 1'b1);
      send(CMD_ALLOC, 32'hFFFF_FFFF);
      send(CMD_ALLOC, 32'h0000_0000);
      send(CMD_RELEASE, 32'h0000_0FFF);
      send(CMD_ALLOC, 32'h5A5A_5A5A);
      send(CMD_RELEASE, 32'h0002_0000);
      send(CMD_RELEASE, 32'hFFFF_FFFF);
      send(CMD_RELEASE, 32'hFFFF_DFFF);
      send(CMD_RELEASE, 32'h0000_1000);
      send(CMD_RELEASE, 32'h0000_1ABC);

      wait_idle();
      configure(32'h0000_0000, 1, 1'b0, 32'hFFFF_E000, 2047, 1'b1);
      repeat (4) send(CMD_ALLOC, $urandom);
      send(CMD_RELEASE, 32'h0000_0000);

      wait_idle();
      configure(32'h0000_0000, 0, 1'b0, 32'hFFFF_E000, 0, 1'b0);
      send(CMD_ALLOC, 32'h0000_0000);
      send(CMD_RELEASE, 32'h0000_1000);
      send(CMD_RELEASE, 32'hFFFF_F000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         sender_idle_pct = (phase < 2) ? 37 : (phase < 4) ? 49 : 0;
         program_random_regions();
         alloc_pct = $urandom_range(75, 35);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < alloc_pct) begin
               send(CMD_ALLOC, $urandom);
            end else begin
               send(CMD_RELEASE, pick_release_addr());
            end
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("tb_frame_bitmap_allocator_top: PASS");
      end else begin
         $display("tb_frame_bitmap_allocator_top: FAIL");
      end
      $finish;
   end

endmodule
